/* src/ident_string_extractor_defines.svh */
// Assertion macros shared by the identification string extractor sources.
// Depends on nothing; the SYNTH macro selects empty bodies for synthesis.
`ifndef IDENT_STRING_EXTRACTOR_DEFINES_SVH
`define IDENT_STRING_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ISE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ISE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ISE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ISE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/ise_pkg.sv */
// Shared types and constants of the identification string extractor.
// Used by ise_scan, ise_result_queue and ident_string_extractor.
package ise_pkg;

    // Character codes the scanner looks for.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_D = 8'h64;

    // Scan mode codes.
    localparam logic [1:0] MODE_SEARCH  = 2'd0;
    localparam logic [1:0] MODE_LEAD    = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_STOPPED = 2'd3;

    // Result kind codes.
    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_END_STR = 2'd1;
    localparam logic [1:0] KIND_END_FILE = 2'd2;

    localparam int MAX_RESULTS = 6;
    localparam int RES_IDX_W   = 3;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic       file_matched;
    } result_t;

    // All results caused by one input item, in delivery order from index 0.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [RES_IDX_W-1:0]      count;
    } bundle_t;

    typedef struct packed {
        logic [23:0] recent_bytes;
        logic [1:0]  scan_mode;
        logic [23:0] held_marker_bytes;
        logic [1:0]  held_marker_count;
        logic [15:0] pending_tail_bytes;
        logic [1:0]  pending_tail_count;
        logic [1:0]  string_length_sat;
        logic        file_hit;
    } scan_state_t;

endpackage

/* src/ise_scan.sv */
// Scanner state and the single-pass logic that turns one item into a result bundle.
// Depends on ise_pkg and ident_string_extractor_defines.svh.
`include "ident_string_extractor_defines.svh"

module ise_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ise_pkg::in_item_t item,
    input  logic              single_only,
    output ise_pkg::bundle_t  bundle
);
    import ise_pkg::*;

    typedef struct packed {
        scan_state_t st;
        bundle_t     bd;
    } work_t;

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [1:0]  lead_k;
    logic [7:0]  lead_first;

    function automatic work_t emit(work_t w, logic [1:0] k, logic [7:0] b, logic m);
        work_t r;
        r = w;
        r.bd.res[r.bd.count].kind         = k;
        r.bd.res[r.bd.count].text_byte    = b;
        r.bd.res[r.bd.count].file_matched = m;
        r.bd.count = r.bd.count + 3'd1;
        return r;
    endfunction

    function automatic logic is_term(logic [7:0] c);
        return c == CH_NUL || c == CH_LT || c == CH_GT || c == CH_DQUOTE ||
               c == CH_BSLASH || c == CH_NL;
    endfunction

    function automatic logic [7:0] held_byte(logic [23:0] held, logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = held[7:0];
            2'd1:    b = held[15:8];
            default: b = held[23:16];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] marker_want(logic [7:0] first, logic [1:0] k);
        logic [7:0] b;
        if (first == CH_AT) begin
            case (k)
                2'd1:    b = CH_LPAREN;
                2'd2:    b = CH_HASH;
                default: b = CH_RPAREN;
            endcase
        end else begin
            case (k)
                2'd1:    b = CH_UPPER_I;
                2'd2:    b = CH_LOWER_D;
                default: b = CH_COLON;
            endcase
        end
        return b;
    endfunction

    // The two newest string bytes stay back until it is known whether they
    // are a trailing space-dollar pair.
    function automatic work_t push_string(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (r.st.pending_tail_count >= 2'd2) begin
            r = emit(r, KIND_TEXT, r.st.pending_tail_bytes[15:8], 1'b0);
        end else begin
            r.st.pending_tail_count = r.st.pending_tail_count + 2'd1;
        end
        r.st.pending_tail_bytes = {r.st.pending_tail_bytes[7:0], c};
        if (r.st.string_length_sat != 2'd3) begin
            r.st.string_length_sat = r.st.string_length_sat + 2'd1;
        end
        return r;
    endfunction

    function automatic work_t end_string(work_t w, logic single);
        work_t r;
        logic  trim;
        r = w;
        trim = (r.st.string_length_sat == 2'd3) && (r.st.pending_tail_count >= 2'd2) &&
               (r.st.pending_tail_bytes == {CH_SPACE, CH_DOLLAR});
        if (!trim) begin
            if (r.st.pending_tail_count >= 2'd2) begin
                r = emit(r, KIND_TEXT, r.st.pending_tail_bytes[15:8], 1'b0);
            end
            if (r.st.pending_tail_count >= 2'd1) begin
                r = emit(r, KIND_TEXT, r.st.pending_tail_bytes[7:0], 1'b0);
            end
        end
        if (r.st.string_length_sat != 2'd0) begin
            r = emit(r, KIND_END_STR, 8'h00, 1'b0);
            r.st.file_hit  = 1'b1;
            r.st.scan_mode = single ? MODE_STOPPED : MODE_SEARCH;
        end else begin
            r.st.scan_mode = MODE_SEARCH;
        end
        r.st.pending_tail_bytes = '0;
        r.st.pending_tail_count = '0;
        r.st.string_length_sat  = '0;
        return r;
    endfunction

    // Bytes of a broken repeated marker become the start of the string, oldest first.
    function automatic work_t flush_held(work_t w);
        work_t r;
        r = w;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < w.st.held_marker_count) begin
                r = push_string(r, held_byte(w.st.held_marker_bytes,
                                             w.st.held_marker_count - 2'(i) - 2'd1));
            end
        end
        r.st.held_marker_bytes = '0;
        r.st.held_marker_count = '0;
        r.st.scan_mode         = MODE_STRING;
        return r;
    endfunction

    function automatic work_t string_byte(work_t w, logic [7:0] c, logic single);
        work_t r;
        r = w;
        r.st.scan_mode = MODE_STRING;
        if (is_term(c)) begin
            r = end_string(r, single);
        end else begin
            r = push_string(r, c);
        end
        return r;
    endfunction

    always_comb begin
        work_t w;
        w.st = state_reg;
        w.bd = '0;
        lead_k     = w.st.held_marker_count;
        lead_first = held_byte(w.st.held_marker_bytes, lead_k - 2'd1);
        if (item.byte_present) begin
            case (w.st.scan_mode)
                MODE_SEARCH: begin
                    if ((item.data_byte == CH_RPAREN &&
                         w.st.recent_bytes == {CH_AT, CH_LPAREN, CH_HASH}) ||
                        (item.data_byte == CH_COLON &&
                         w.st.recent_bytes == {CH_DOLLAR, CH_UPPER_I, CH_LOWER_D})) begin
                        w.st.scan_mode         = MODE_LEAD;
                        w.st.held_marker_bytes = '0;
                        w.st.held_marker_count = '0;
                    end
                end
                MODE_LEAD: begin
                    if (lead_k == 2'd0) begin
                        if (item.data_byte == CH_SPACE || item.data_byte == CH_TAB) begin
                            w.st.scan_mode = MODE_LEAD;
                        end else if (item.data_byte == CH_AT ||
                                     item.data_byte == CH_DOLLAR) begin
                            w.st.held_marker_bytes = {16'h0000, item.data_byte};
                            w.st.held_marker_count = 2'd1;
                        end else begin
                            w = string_byte(w, item.data_byte, single_only);
                        end
                    end else if (item.data_byte == marker_want(lead_first, lead_k)) begin
                        // A complete repeated marker is dropped silently.
                        if (lead_k == 2'd3) begin
                            w.st.held_marker_bytes = '0;
                            w.st.held_marker_count = '0;
                        end else begin
                            w.st.held_marker_bytes = {w.st.held_marker_bytes[15:0],
                                                      item.data_byte};
                            w.st.held_marker_count = lead_k + 2'd1;
                        end
                    end else begin
                        w = flush_held(w);
                        w = string_byte(w, item.data_byte, single_only);
                    end
                end
                MODE_STRING: begin
                    w = string_byte(w, item.data_byte, single_only);
                end
                default: begin
                    w.st.scan_mode = MODE_STOPPED;
                end
            endcase
            w.st.recent_bytes = {w.st.recent_bytes[15:0], item.data_byte};
        end
        if (item.end_of_file) begin
            if (w.st.scan_mode == MODE_LEAD && w.st.held_marker_count != 2'd0) begin
                w = flush_held(w);
            end
            if (w.st.scan_mode == MODE_STRING) begin
                w = end_string(w, single_only);
            end
            w = emit(w, KIND_END_FILE, 8'h00, w.st.file_hit);
            w.st = '0;
        end
        state_next = w.st;
        bundle     = w.bd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    `ISE_ASSERT_NXT(a_eof_clears, aclk, aresetn, fire && item.end_of_file, state_reg == '0, "file end did not clear the scan state")
    `ISE_ASSERT_IMP(a_stop_needs_single, aclk, aresetn, fire && state_next.scan_mode == MODE_STOPPED, single_only, "scan stopped outside single mode")

endmodule

/* src/ise_result_queue.sv */
// Queue of result bundles and the serializer that hands out one result per transfer.
// Depends on ise_pkg and ident_string_extractor_defines.svh.
`include "ident_string_extractor_defines.svh"

module ise_result_queue #(
    parameter int DEPTH = ise_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  ise_pkg::bundle_t                push_bundle,
    output logic                            full,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ise_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser
);
    import ise_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     used_next;
    logic [RES_IDX_W-1:0] idx_reg;
    bundle_t              head;
    result_t              cur;
    logic                 last_sub;
    logic                 pop;

    assign head     = entry_reg[rd_ptr_reg];
    assign cur      = head.res[idx_reg];
    assign m_tvalid = (used_reg != '0);
    assign m_tdata  = {{(OUT_TDATA_W - 9){1'b0}}, cur.file_matched, cur.text_byte};
    assign m_tuser  = cur.kind;
    assign full     = (used_reg == CNT_W'(DEPTH));
    assign last_sub = (idx_reg == head.count - 3'd1);
    assign pop      = m_tvalid && m_tready && last_sub;

    always_comb begin
        case ({push, pop})
            2'b10:   used_next = used_reg + 1'b1;
            2'b01:   used_next = used_reg - 1'b1;
            default: used_next = used_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            used_reg <= used_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                idx_reg    <= '0;
            end else if (m_tvalid && m_tready) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    `ISE_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !full, "bundle pushed into a full queue")
    `ISE_ASSERT_IMP(a_push_count, aclk, aresetn, push, push_bundle.count != '0 && push_bundle.count <= RES_IDX_W'(MAX_RESULTS), "pushed bundle has a bad result count")
    `ISE_ASSERT_IMP(a_idx_in_bundle, aclk, aresetn, m_tvalid, idx_reg < head.count, "result index ran past its bundle")
    `ISE_ASSERT_NXT(a_drain_empty, aclk, aresetn, pop && used_reg == CNT_W'(1) && !push, !m_tvalid, "queue still valid after its last result")

endmodule

/* src/ident_string_extractor.sv */
// Top level of the identification string extractor: input register, mode register,
// scanner and result queue. Depends on ise_pkg, ise_scan and ise_result_queue.
//
// Scans a byte stream for @(#) and $Id: markers and delivers the text after each marker
// (only the first per file if single_only is set) as text-byte results closed by an
// end-of-string result, plus one summary result at every file end. One byte transfer
// is taken per clock cycle while the queue is not full; a byte passes the input register,
// then the result queue. A byte causes zero to six results; results leave one per cycle
// while m_tready is high, so the output port sets the sustained rate when strings are
// found: the queue holds QUEUE_DEPTH bundles, and the input stalls only once it is full.
// The user must write single_only through cfg_wr_en while idle; the block does not check.
module ident_string_extractor #(
    parameter int QUEUE_DEPTH = ise_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] byte_present
    input  logic                            s_tlast,   // end_of_file
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ise_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] text_byte, [8] file_matched
    output logic [1:0]                      m_tuser    // [1:0] kind
);
    import ise_pkg::*;

    logic     single_only_reg;
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     fire;
    logic     queue_full;
    bundle_t  bundle;

    assign fire     = in_valid_reg && !queue_full;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            single_only_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                single_only_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data_byte    <= s_tdata;
            in_item_reg.byte_present <= s_tuser;
            in_item_reg.end_of_file  <= s_tlast;
        end
    end

    ise_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (in_item_reg),
        .single_only (single_only_reg),
        .bundle      (bundle)
    );

    // Items that cause no result never enter the queue.
    ise_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (fire && (bundle.count != '0)),
        .push_bundle (bundle),
        .full        (queue_full),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
